[design/nss_pkg.sv]
// Package for the NCO setting search: constants, stage types and the prescaler table.
// It depends on nothing; every other file of the block but nss_req_if uses it.
package nss_pkg;

   localparam int PHASE_FRACTION_BITS = 17;
   localparam int TUNING_WORD_WIDTH   = 16;
   localparam int SEL_COUNT           = 8;
   localparam int SEL_W               = 3;
   localparam int MIN_SHIFT           = 1;
   localparam int MAX_SHIFT           = 12;
   // Largest and smallest total shift n over all prescalers.
   localparam int MAX_N               = PHASE_FRACTION_BITS + MAX_SHIFT;
   localparam int MIN_N               = PHASE_FRACTION_BITS + MIN_SHIFT;
   localparam int SH_W                = $clog2(MAX_N + 1);
   // One division cell for each bit of the dividend target << MAX_N.
   localparam int DIV_STEPS           = 32 + MAX_N;
   // Quotient bits that any prescaler reads.
   localparam int QW                  = MAX_N - MIN_N + TUNING_WORD_WIDTH;
   localparam int PROD_W              = 32 + TUNING_WORD_WIDTH;

   localparam logic [31:0] CLOCK_RESET = 32'd100000000;
   localparam logic [31:0] ERR_INIT    = 32'hffffffff;
   localparam logic [1:0]  NO_CHANNEL  = 2'd3;

   typedef struct packed {
      logic                  valid;
      logic [1:0]            channel;
      logic [31:0]           target;
      logic                  oor;
      logic                  czero;
      logic [31:0]           rem;
      logic [QW-1:0]         quo;
   } div_stage_type;

   typedef struct packed {
      logic                          valid;
      logic [1:0]                    channel;
      logic [31:0]                   target;
      logic                          oor;
      logic                          czero;
      logic [QW-1:0]                 quo;
      logic [31:0]                   best_err;
      logic [TUNING_WORD_WIDTH-1:0]  best_tw;
      logic [SEL_W-1:0]              best_sel;
      logic [31:0]                   best_act;
   } eval_stage_type;

   // Prescaler selector to shift.
   function automatic logic [SH_W-1:0] shift_of(input logic [SEL_W-1:0] sel);
      logic [SH_W-1:0] s;
      unique case (sel)
         3'd0: s = SH_W'(1);
         3'd1: s = SH_W'(2);
         3'd2: s = SH_W'(3);
         3'd3: s = SH_W'(6);
         3'd4: s = SH_W'(7);
         3'd5: s = SH_W'(10);
         3'd6: s = SH_W'(11);
         default: s = SH_W'(12);
      endcase
      return s;
   endfunction

endpackage

[design/nss_req_if.sv]
// Request channel interface of the NCO setting search: valid, ready, channel and target.
// Uses nothing but plain logic types.
interface nss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  channel;
   logic [31:0] target_hz;

   modport source (output valid, channel, target_hz, input ready);
   modport sink (input valid, channel, target_hz, output ready);
endinterface

[design/nss_rsp_if.sv]
// Response channel interface of the NCO setting search: valid, ready and the result fields.
// Depends on nss_pkg for the tuning word width.
interface nss_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  write_strobe;
   logic [1:0]                            out_channel;
   logic [nss_pkg::TUNING_WORD_WIDTH-1:0] phase_step;
   logic [2:0]                            prescaler_select;
   logic [31:0]                           actual_hz;
   logic                                  out_of_range;

   modport source (output valid, write_strobe, out_channel, phase_step, prescaler_select,
                   actual_hz, out_of_range, input ready);
   modport sink (input valid, write_strobe, out_channel, phase_step, prescaler_select,
                 actual_hz, out_of_range, output ready);
endinterface

[design/nss_div_cell.sv]
// One restoring division step: brings in one dividend bit and forms one quotient bit.
// Depends on nss_pkg for the stage type.
module nss_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [31:0]            clock_hz,
   input  logic                   div_bit,
   input  nss_pkg::div_stage_type stage_in,
   output nss_pkg::div_stage_type stage_out
);

   nss_pkg::div_stage_type stage_ff, stage_in_w;
   logic [32:0] trial;
   logic        ge;

   // Shift in the next bit and subtract the divisor when it fits.
   always_comb begin
      trial      = {stage_in.rem, div_bit};
      ge         = (trial >= {1'b0, clock_hz});
      stage_in_w = stage_in;
      stage_in_w.rem = ge ? 32'(trial - {1'b0, clock_hz}) : trial[31:0];
      stage_in_w.quo = {stage_in.quo[nss_pkg::QW-2:0], ge};
   end

   // Valid bit under reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_w.valid;
      end
   end

   // Payload moves on with the pipeline.
   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.channel <= stage_in_w.channel;
         stage_ff.target  <= stage_in_w.target;
         stage_ff.oor     <= stage_in_w.oor;
         stage_ff.czero   <= stage_in_w.czero;
         stage_ff.rem     <= stage_in_w.rem;
         stage_ff.quo     <= stage_in_w.quo;
      end
   end

   assign stage_out = stage_ff;

endmodule

[design/nss_eval_cell.sv]
// Evaluates one prescaler: forms its tuning word and product, then keeps the better setting.
// Depends on nss_pkg for the stage type and the prescaler table.
module nss_eval_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [31:0]                 clock_hz,
   input  logic [nss_pkg::SEL_W-1:0]   sel,
   input  nss_pkg::eval_stage_type     stage_in,
   output nss_pkg::eval_stage_type     stage_out
);

   localparam int TWW = nss_pkg::TUNING_WORD_WIDTH;

   nss_pkg::eval_stage_type mid_ff, stage_ff, stage_in_w;
   logic [TWW-1:0]              cand_tw_ff, cand_tw_in;
   logic [nss_pkg::PROD_W-1:0]  cand_prod_ff, cand_prod_in;
   logic [nss_pkg::SH_W-1:0]    n_w;
   logic [nss_pkg::QW-1:0]      q_shifted;
   logic [TWW-1:0]              tw1;
   logic [nss_pkg::PROD_W-1:0]  p_shifted;
   logic [31:0]                 act, err;

   assign n_w = nss_pkg::SH_W'(nss_pkg::PHASE_FRACTION_BITS) + nss_pkg::shift_of(sel);

   // First half: pick the quotient slice and multiply the clock by the next word.
   always_comb begin
      q_shifted    = stage_in.quo >> (nss_pkg::SH_W'(nss_pkg::MAX_N) - n_w);
      cand_tw_in   = stage_in.czero ? '0 : q_shifted[TWW-1:0];
      tw1          = cand_tw_in + TWW'(1);
      cand_prod_in = nss_pkg::PROD_W'(clock_hz) * nss_pkg::PROD_W'(tw1);
   end

   // Second half: actual frequency, error and strict compare against the best so far.
   always_comb begin
      p_shifted  = cand_prod_ff >> n_w;
      act        = p_shifted[31:0];
      err        = (act >= mid_ff.target) ? (act - mid_ff.target) : (mid_ff.target - act);
      stage_in_w = mid_ff;
      if (!mid_ff.oor && (err < mid_ff.best_err)) begin
         stage_in_w.best_err = err;
         stage_in_w.best_tw  = cand_tw_ff;
         stage_in_w.best_sel = sel;
         stage_in_w.best_act = act;
      end
   end

   // Valid bits under reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid   <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         mid_ff.valid   <= stage_in.valid;
         stage_ff.valid <= stage_in_w.valid;
      end
   end

   // Payload of both halves.
   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff.channel  <= stage_in.channel;
         mid_ff.target   <= stage_in.target;
         mid_ff.oor      <= stage_in.oor;
         mid_ff.czero    <= stage_in.czero;
         mid_ff.quo      <= stage_in.quo;
         mid_ff.best_err <= stage_in.best_err;
         mid_ff.best_tw  <= stage_in.best_tw;
         mid_ff.best_sel <= stage_in.best_sel;
         mid_ff.best_act <= stage_in.best_act;
         cand_tw_ff      <= cand_tw_in;
         cand_prod_ff    <= cand_prod_in;
         stage_ff.channel  <= stage_in_w.channel;
         stage_ff.target   <= stage_in_w.target;
         stage_ff.oor      <= stage_in_w.oor;
         stage_ff.czero    <= stage_in_w.czero;
         stage_ff.quo      <= stage_in_w.quo;
         stage_ff.best_err <= stage_in_w.best_err;
         stage_ff.best_tw  <= stage_in_w.best_tw;
         stage_ff.best_sel <= stage_in_w.best_sel;
         stage_ff.best_act <= stage_in_w.best_act;
      end
   end

   assign stage_out = stage_ff;

endmodule

[design/nco_setting_search.sv]
// Top level of the NCO setting search: division chain, prescaler evaluation chain, clock register.
// Depends on nss_pkg, nss_req_if, nss_rsp_if, nss_div_cell and nss_eval_cell.

// The block takes one item per cycle while its output is not stalled: 61 division cells
// each form one quotient bit of (target << 29) / clock_hz, and the quotient of every
// prescaler is a slice of that one quotient; then eight evaluation cells, each with a
// middle and an output register, try the selectors 7 down to 0, one 32 by 16 bit multiply
// per cell. The whole chain moves together, so a stalled result holds every item behind it.
// The clock_hz register resets to 100 MHz and may be written only while no item is in flight.
module nco_setting_search (
   input  logic          clock,
   input  logic          reset,
   nss_req_if.sink       req_chan,
   nss_rsp_if.source     rsp_chan,
   input  logic          csr_write_enable,
   input  logic [31:0]   csr_write_data
);

   localparam int STEPS = nss_pkg::DIV_STEPS;
   localparam int SELS  = nss_pkg::SEL_COUNT;

   logic [31:0] clock_hz_ff;
   logic        advance;
   nss_pkg::div_stage_type  div_chain [STEPS+1];
   nss_pkg::eval_stage_type eval_chain [SELS+1];

   // Clock frequency register.
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= nss_pkg::CLOCK_RESET;
      end else if (csr_write_enable) begin
         clock_hz_ff <= csr_write_data;
      end
   end

   // The chain moves whenever the output register is free or being taken.
   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Item entering the division chain.
   always_comb begin
      div_chain[0].valid   = req_chan.valid;
      div_chain[0].channel = req_chan.channel;
      div_chain[0].target  = req_chan.target_hz;
      div_chain[0].oor     = req_chan.target_hz > (clock_hz_ff >> 2);
      div_chain[0].czero   = (clock_hz_ff == 32'd0);
      div_chain[0].rem     = '0;
      div_chain[0].quo     = '0;
   end

   // Division cells, dividend bits from the top down.
   for (genvar i = 0; i < STEPS; i++) begin : g_div
      localparam int J = STEPS - 1 - i;
      logic dbit;
      if (J >= nss_pkg::MAX_N) begin : g_tbit
         assign dbit = div_chain[i].target[J - nss_pkg::MAX_N];
      end else begin : g_zero
         assign dbit = 1'b0;
      end
      nss_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .clock_hz  (clock_hz_ff),
         .div_bit   (dbit),
         .stage_in  (div_chain[i]),
         .stage_out (div_chain[i+1])
      );
   end

   // Hand the quotient to the evaluation chain with an empty best setting.
   always_comb begin
      eval_chain[0].valid    = div_chain[STEPS].valid;
      eval_chain[0].channel  = div_chain[STEPS].channel;
      eval_chain[0].target   = div_chain[STEPS].target;
      eval_chain[0].oor      = div_chain[STEPS].oor;
      eval_chain[0].czero    = div_chain[STEPS].czero;
      eval_chain[0].quo      = div_chain[STEPS].quo;
      eval_chain[0].best_err = nss_pkg::ERR_INIT;
      eval_chain[0].best_tw  = '0;
      eval_chain[0].best_sel = '0;
      eval_chain[0].best_act = '0;
   end

   // Evaluation cells, highest selector first so that it wins a tie.
   for (genvar k = 0; k < SELS; k++) begin : g_eval
      nss_eval_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .clock_hz  (clock_hz_ff),
         .sel       (nss_pkg::SEL_W'(SELS - 1 - k)),
         .stage_in  (eval_chain[k]),
         .stage_out (eval_chain[k+1])
      );
   end

   // The last cell's register is the output register.
   assign rsp_chan.valid            = eval_chain[SELS].valid;
   assign rsp_chan.write_strobe     = !eval_chain[SELS].oor &&
                                      (eval_chain[SELS].channel != nss_pkg::NO_CHANNEL);
   assign rsp_chan.out_channel      = eval_chain[SELS].channel;
   assign rsp_chan.phase_step       = eval_chain[SELS].best_tw;
   assign rsp_chan.prescaler_select = eval_chain[SELS].best_sel;
   assign rsp_chan.actual_hz        = eval_chain[SELS].best_act;
   assign rsp_chan.out_of_range     = eval_chain[SELS].oor;

endmodule

[design/nss_checker.sv]
// Port-level checks of the NCO setting search, bound to the top level.
// Depends on nss_pkg and on the ports of nco_setting_search.
module nss_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  write_strobe,
   input logic [1:0]                            out_channel,
   input logic [nss_pkg::TUNING_WORD_WIDTH-1:0] phase_step,
   input logic [2:0]                            prescaler_select,
   input logic [31:0]                           actual_hz,
   input logic                                  out_of_range
);

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(actual_hz) && $stable(phase_step)
         && $stable(prescaler_select) && $stable(out_channel))
      else $error("stalled result item changed");

   // An out of range target gives an empty setting and no write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_of_range |-> !write_strobe && phase_step == '0
         && prescaler_select == 3'd0 && actual_hz == 32'd0)
      else $error("out of range result not empty");

   // The strobe follows the range flag and the channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> write_strobe == (!out_of_range && out_channel != nss_pkg::NO_CHANNEL))
      else $error("write strobe wrong");

   // The input side moves exactly when the output register is free or being taken.
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the output register");

endmodule

bind nco_setting_search nss_checker u_nss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .write_strobe     (rsp_chan.write_strobe),
   .out_channel      (rsp_chan.out_channel),
   .phase_step       (rsp_chan.phase_step),
   .prescaler_select (rsp_chan.prescaler_select),
   .actual_hz        (rsp_chan.actual_hz),
   .out_of_range     (rsp_chan.out_of_range)
);
